// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL.
// Depends on nothing; the bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- rtl/core/tah_pkg.sv -----
// Widths, stage counts and the control struct of the triangle area core.
// Used by tah_front, tah_sqrt_step and triangle_area_heron_core.
package tah_pkg;

  localparam int SIDE_W  = 16;
  localparam int SUM_W   = SIDE_W + 2;
  localparam int DIFF_W  = SIDE_W + 1;
  localparam int U_W     = SUM_W + DIFF_W;
  localparam int V_W     = 2 * DIFF_W;
  localparam int PART_W  = U_W + DIFF_W;
  localparam int PROD_W  = U_W + V_W;
  localparam int ROOT_W  = 2 * SIDE_W - 1;
  localparam int Q_W     = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int FRONT_STAGES = 4;
  localparam int STAGES  = FRONT_STAGES + ROOT_W;

  typedef struct packed {
    logic valid;
    logic tri_ok;
  } ctl_t;

endpackage

// ----- rtl/core/tah_front.sv -----
// Front end: triangle check, Heron terms, product of the four terms over 16.
// Four register stages; depends on tah_pkg.
module tah_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tah_pkg::FRONT_STAGES-1:0] en,
  input  logic                        in_valid,
  input  logic [tah_pkg::SIDE_W-1:0]  side_a,
  input  logic [tah_pkg::SIDE_W-1:0]  side_b,
  input  logic [tah_pkg::SIDE_W-1:0]  side_c,
  output logic [tah_pkg::FRONT_STAGES-1:0] stage_valid,
  output tah_pkg::ctl_t               ctl_out,
  output logic [tah_pkg::Q_W-1:0]     q_out
);

  logic [tah_pkg::DIFF_W-1:0] ab, bc, ac;
  logic                       ok_next;
  logic [tah_pkg::SUM_W-1:0]  t1_next;
  logic [tah_pkg::DIFF_W-1:0] t2_next, t3_next, t4_next;

  tah_pkg::ctl_t              ctl1, ctl2, ctl3;
  logic [tah_pkg::SUM_W-1:0]  t1;
  logic [tah_pkg::DIFF_W-1:0] t2, t3, t4;
  logic [tah_pkg::U_W-1:0]    u, u_next;
  logic [tah_pkg::V_W-1:0]    v, v_next;
  logic [tah_pkg::PART_W-1:0] pl, ph, pl_next, ph_next;
  logic [tah_pkg::PROD_W-1:0] prod;

  assign ab = {1'b0, side_a} + {1'b0, side_b};
  assign bc = {1'b0, side_b} + {1'b0, side_c};
  assign ac = {1'b0, side_a} + {1'b0, side_c};
  assign ok_next = (ab > {1'b0, side_c}) && (bc > {1'b0, side_a}) && (ac > {1'b0, side_b});

  // zero every term of a non-triangle so the root comes out zero
  assign t1_next = ok_next ? ({1'b0, ab} + {2'b00, side_c}) : '0;
  assign t2_next = ok_next ? (bc - {1'b0, side_a}) : '0;
  assign t3_next = ok_next ? (ac - {1'b0, side_b}) : '0;
  assign t4_next = ok_next ? (ab - {1'b0, side_c}) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (en[0]) begin
      ctl1.valid  <= in_valid;
      ctl1.tri_ok <= ok_next;
      t1 <= t1_next;
      t2 <= t2_next;
      t3 <= t3_next;
      t4 <= t4_next;
    end
  end

  assign u_next = t1 * t2;
  assign v_next = t3 * t4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (en[1]) begin
      ctl2 <= ctl1;
      u    <= u_next;
      v    <= v_next;
    end
  end

  // split v so that each product stays narrow
  assign pl_next = u * v[tah_pkg::DIFF_W-1:0];
  assign ph_next = u * v[tah_pkg::V_W-1:tah_pkg::DIFF_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (en[2]) begin
      ctl3 <= ctl2;
      pl   <= pl_next;
      ph   <= ph_next;
    end
  end

  assign prod = {ph, {tah_pkg::DIFF_W{1'b0}}} + {{(tah_pkg::PROD_W-tah_pkg::PART_W){1'b0}}, pl};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en[3]) begin
      ctl_out <= ctl3;
      q_out   <= prod[tah_pkg::Q_W+3:4];
    end
  end

  assign stage_valid = {ctl_out.valid, ctl3.valid, ctl2.valid, ctl1.valid};

endmodule

// ----- rtl/core/tah_sqrt_step.sv -----
// One registered step of the digit-by-digit integer square root.
// Takes two radicand bits per step; depends on tah_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tah_sqrt_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tah_pkg::ctl_t               ctl_in,
  input  logic [tah_pkg::REM_W-1:0]   rem_in,
  input  logic [tah_pkg::ROOT_W-1:0]  root_in,
  input  logic [tah_pkg::Q_W-1:0]     q_in,
  output tah_pkg::ctl_t               ctl_out,
  output logic [tah_pkg::REM_W-1:0]   rem_out,
  output logic [tah_pkg::ROOT_W-1:0]  root_out,
  output logic [tah_pkg::Q_W-1:0]     q_out
);

  logic [tah_pkg::REM_W+1:0] shifted;
  logic [tah_pkg::REM_W+1:0] trial;
  logic [tah_pkg::REM_W+1:0] diff;
  logic                      take;

  assign shifted = {rem_in, q_in[tah_pkg::Q_W-1:tah_pkg::Q_W-2]};
  assign trial   = {2'b00, root_in, 2'b01};
  assign diff    = shifted - trial;
  assign take    = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out  <= ctl_in;
      rem_out  <= take ? diff[tah_pkg::REM_W-1:0] : shifted[tah_pkg::REM_W-1:0];
      root_out <= {root_in[tah_pkg::ROOT_W-2:0], take};
      q_out    <= {q_in[tah_pkg::Q_W-3:0], 2'b00};
    end
  end

  `ASSERT_PROP(a_rem_bound, clk, rst, ctl_out.valid |-> rem_out <= {1'b0, root_out, 1'b0})
  `ASSERT_PROP(a_advance, clk, rst, en && ctl_in.valid |=> ctl_out.valid)

endmodule

// ----- rtl/core/triangle_area_heron_core.sv -----
// Top level of the Heron triangle area core: stage handshake and sqrt chain.
// Depends on tah_pkg, tah_front, tah_sqrt_step and assert_macros.svh.
//
// Use: present side_a, side_b, side_c (8 fractional bits) with in_valid;
// the item is taken on a clock edge where in_valid is high and in_stall low.
// Each item gives one result: is_triangle and area (units of 2^-16), shown
// with out_valid and taken when out_stall is low.
// The pipeline has four front stages (check and terms, two multiply
// stages, product sum) and 31 square-root stages, one root bit each.
// It takes one item per cycle while in_stall is low; every stage advances
// on its own when the stage after it is empty or moving, so bubbles close
// up under back-pressure. When out_stall is high the result holds; in_stall
// rises only once every stage holds an item. A synchronous reset empties the
// pipeline; no result is lost or repeated across a stall.
`include "assert_macros.svh"

module triangle_area_heron_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tah_pkg::SIDE_W-1:0]  side_a,
  input  logic [tah_pkg::SIDE_W-1:0]  side_b,
  input  logic [tah_pkg::SIDE_W-1:0]  side_c,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_triangle,
  output logic [tah_pkg::ROOT_W-1:0]  area
);

  logic [tah_pkg::STAGES-1:0] stage_valid;
  logic [tah_pkg::STAGES-1:0] stage_en;

  tah_pkg::ctl_t              ctl  [tah_pkg::ROOT_W+1];
  logic [tah_pkg::REM_W-1:0]  rem  [tah_pkg::ROOT_W+1];
  logic [tah_pkg::ROOT_W-1:0] root [tah_pkg::ROOT_W+1];
  logic [tah_pkg::Q_W-1:0]    q    [tah_pkg::ROOT_W+1];

  // advance a stage when it is empty or the next stage advances
  genvar k;
  generate
    for (k = 0; k < tah_pkg::STAGES - 1; k++) begin : g_en
      assign stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  endgenerate
  assign stage_en[tah_pkg::STAGES-1] = !stage_valid[tah_pkg::STAGES-1] || !out_stall;
  assign in_stall = !stage_en[0];

  tah_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (stage_en[tah_pkg::FRONT_STAGES-1:0]),
    .in_valid    (in_valid),
    .side_a      (side_a),
    .side_b      (side_b),
    .side_c      (side_c),
    .stage_valid (stage_valid[tah_pkg::FRONT_STAGES-1:0]),
    .ctl_out     (ctl[0]),
    .q_out       (q[0])
  );

  assign rem[0]  = '0;
  assign root[0] = '0;

  generate
    for (k = 0; k < tah_pkg::ROOT_W; k++) begin : g_sqrt
      tah_sqrt_step u_step (
        .clk      (clk),
        .rst      (rst),
        .en       (stage_en[tah_pkg::FRONT_STAGES+k]),
        .ctl_in   (ctl[k]),
        .rem_in   (rem[k]),
        .root_in  (root[k]),
        .q_in     (q[k]),
        .ctl_out  (ctl[k+1]),
        .rem_out  (rem[k+1]),
        .root_out (root[k+1]),
        .q_out    (q[k+1])
      );
      assign stage_valid[tah_pkg::FRONT_STAGES+k] = ctl[k+1].valid;
    end
  endgenerate

  assign out_valid   = ctl[tah_pkg::ROOT_W].valid;
  assign is_triangle = ctl[tah_pkg::ROOT_W].tri_ok;
  assign area        = root[tah_pkg::ROOT_W];

  `ASSERT_PROP(a_zero_area, clk, rst, out_valid && !is_triangle |-> area == '0)
  `ASSERT_PROP(a_full_on_stall, clk, rst, in_stall |-> out_stall && (&stage_valid))
  `ASSERT_NEVER(a_stall_free, clk, rst, in_stall && !out_stall)

endmodule
